/* sv/msq_pkg.sv */
// ============================================================================
// msq_pkg
// Shared types and constants for the marching-squares cell core.
// ============================================================================
package msq_pkg;

   localparam int MAX_ROW_POINTS_DEF = 1024;
   localparam int COORD_W = 32;
   localparam int PPR_W = 11;
   localparam int AXIS_W = 2;
   localparam int CSR_IDX_W = 2;
   localparam int T_W = 32;       // Q2.30 fraction, value at most 2^30
   localparam int DIFF_W = 33;    // coordinate minus level
   localparam int MAG_W = 34;     // sum of two magnitudes

   localparam logic [CSR_IDX_W-1:0] REG_AXIS_SELECT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL_VALUE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_POINTS_PER_ROW = 2'd2;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   typedef struct packed {
      point_type a;
      point_type b;
      logic      last;
   } segment_type;

   // controller -> datapath
   typedef struct packed {
      logic       load;       // capture item, read store
      logic       classify;   // corners ready, compute sides
      logic       div_start;  // start divider on edge_sel
      logic [1:0] edge_sel;
      logic       lerp;       // divider done, interpolate edge_sel
      logic       emit;       // build segment seg_sel into output reg
      logic       seg_sel;
      logic       commit;     // update line store and counters
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       has_cell;
      logic [3:0] cross_mask;
      logic [2:0] cross_count;
      logic       div_done;
   } status_type;

endpackage

/* sv/msq_if.sv */
// ============================================================================
// msq_if
// Valid/ready channels for points, segments and register writes.
// ============================================================================
interface msq_req_if;
   import msq_pkg::*;
   logic      valid;
   logic      ready;
   logic      frame_start;
   coord_type px;
   coord_type py;
   coord_type pz;
   coord_type center_value;
   modport source (output valid, frame_start, px, py, pz, center_value, input ready);
   modport sink (input valid, frame_start, px, py, pz, center_value, output ready);
endinterface

interface msq_rsp_if;
   import msq_pkg::*;
   logic      valid;
   logic      ready;
   coord_type ax;
   coord_type ay;
   coord_type az;
   coord_type bx;
   coord_type by_coord;
   coord_type bz;
   logic      last_segment;
   modport source (output valid, ax, ay, az, bx, by_coord, bz, last_segment, input ready);
   modport sink (input valid, ax, ay, az, bx, by_coord, bz, last_segment, output ready);
endinterface

interface msq_csr_if;
   import msq_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [COORD_W-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* sv/msq_divider.sv */
// ============================================================================
// msq_divider
// Restoring divider, one quotient bit per cycle: t = round(num*2^30 / den).
// ============================================================================
module msq_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [msq_pkg::MAG_W-1:0] num,
   input  logic [msq_pkg::MAG_W-1:0] den,
   output logic                      done,
   output logic [msq_pkg::T_W-1:0]   quot
);
   import msq_pkg::*;

   // dividend = num*2^30 + den/2, below 2^65
   localparam int DVD_W = MAG_W + 31;
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [MAG_W:0]   rem_ff, rem_in;
   logic [MAG_W-1:0] den_ff, den_in;
   logic [DVD_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [MAG_W:0]   trial;
   logic [MAG_W-1:0] den_fix;

   always_comb begin
      den_fix = (den == '0) ? MAG_W'(1) : den;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[MAG_W-1:0], dvd_ff[DVD_W-1]};
      if (start) begin
         dvd_in  = ({num, 30'd0} + DVD_W'(den_fix >> 1));
         rem_in  = '0;
         den_in  = den_fix;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = dvd_ff << 1;
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            q_in   = {q_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff[T_W-1:0];
endmodule

/* sv/msq_datapath.sv */
// ============================================================================
// msq_datapath
// Line store, corner registers, side classification, interpolation, output.
// ============================================================================
module msq_datapath #(
   parameter int MAX_ROW_POINTS = msq_pkg::MAX_ROW_POINTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  msq_pkg::cmd_type            cmd,
   output msq_pkg::status_type         status,
   input  logic                        in_frame_start,
   input  msq_pkg::point_type          in_point,
   input  msq_pkg::coord_type          in_center,
   input  logic [msq_pkg::AXIS_W-1:0]  axis_select,
   input  msq_pkg::coord_type          level_value,
   input  logic [msq_pkg::PPR_W-1:0]   points_per_row,
   output msq_pkg::segment_type        seg_out
);
   import msq_pkg::*;

   localparam int COL_W = $clog2(MAX_ROW_POINTS);
   localparam int CNT_W = $clog2(MAX_ROW_POINTS + 1);

   point_type  mem [MAX_ROW_POINTS];
   point_type  above_ff;
   point_type  left_ff, left_in;
   point_type  upleft_ff;
   point_type  cur_ff;
   coord_type  center_ff;
   logic [CNT_W-1:0] colcnt_ff, colcnt_in;
   logic [CNT_W-1:0] col_ff, col_in;
   logic       prior_ff, prior_in;
   logic       cell_ff;
   logic signed [DIFF_W-1:0] d_ff [4];
   logic [3:0] side_ff;
   logic       c0_center_ff;
   point_type  p_ff [4];
   logic [T_W-1:0] tq;
   logic       dv_done;
   logic [MAG_W-1:0] dnum, dden;
   logic [CNT_W-1:0] nlen;
   logic [PPR_W-1:0] ppr_c;
   point_type  corner [4];
   point_type  ea, eb;
   logic [1:0] enx;
   logic [1:0] ax_sel;
   segment_type seg_ff;

   function automatic logic [MAG_W-1:0] mag_f(input logic signed [DIFF_W-1:0] v);
      logic [DIFF_W-1:0] m;
      m = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
      return MAG_W'(m);
   endfunction

   function automatic coord_type pick(input point_type p, input logic [1:0] s);
      coord_type r;
      unique case (s)
         2'd0:    r = p.x;
         2'd1:    r = p.y;
         default: r = p.z;
      endcase
      return r;
   endfunction

   // a + floor(((b-a)*t + 2^29) / 2^30); one 33x32 multiply per coordinate
   function automatic coord_type lerp_f(input coord_type a, input coord_type b,
                                        input logic [T_W-1:0] t);
      logic signed [32:0] df;
      logic signed [66:0] pr;
      logic signed [36:0] q;
      df = 33'(b) - 33'(a);
      pr = 67'(df) * $signed({35'd0, t}) + 67'sd536870912;
      q  = 37'(pr >>> 30);
      return COORD_W'(37'(a) + q);
   endfunction

   always_comb begin
      ppr_c = points_per_row;
      if (ppr_c < PPR_W'(2)) ppr_c = PPR_W'(2);
      nlen = (32'(ppr_c) > MAX_ROW_POINTS) ? CNT_W'(MAX_ROW_POINTS) : CNT_W'(ppr_c);
      ax_sel = (axis_select == 2'd3) ? 2'd2 : axis_select;
      col_in   = colcnt_ff;
      prior_in = prior_ff;
      if (in_frame_start) begin
         col_in   = '0;
         prior_in = 1'b0;
      end else if (colcnt_ff >= nlen) begin
         col_in   = '0;
         prior_in = 1'b1;
      end
      corner[0] = left_ff;
      corner[1] = cur_ff;
      corner[2] = above_ff;
      corner[3] = upleft_ff;
      enx = cmd.edge_sel + 2'd1;
      ea  = corner[cmd.edge_sel];
      eb  = corner[enx];
      dnum = mag_f(d_ff[cmd.edge_sel]);
      dden = dnum + mag_f(d_ff[enx]);
      left_in   = cur_ff;
      colcnt_in = col_ff + 1'b1;
   end

   msq_divider u_div (
      .clock (clock), .reset (reset), .start (cmd.div_start),
      .num (dnum), .den (dden), .done (dv_done), .quot (tq)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         above_ff <= mem[col_in[COL_W-1:0]];
      end
      if (cmd.commit) begin
         mem[col_ff[COL_W-1:0]] <= cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         upleft_ff <= '0;
         colcnt_ff <= '0;
         prior_ff  <= 1'b0;
         cell_ff   <= 1'b0;
      end else begin
         if (cmd.load) begin
            col_ff   <= col_in;
            prior_ff <= prior_in;
            cell_ff  <= prior_in && (col_in != '0);
         end
         if (cmd.commit) begin
            left_ff   <= left_in;
            upleft_ff <= above_ff;
            if (colcnt_in >= nlen) begin
               colcnt_ff <= '0;
               prior_ff  <= 1'b1;
            end else begin
               colcnt_ff <= colcnt_in;
            end
         end
      end
      if (cmd.load) begin
         cur_ff    <= in_point;
         center_ff <= in_center;
      end
      if (cmd.classify) begin
         for (int k = 0; k < 4; k++) begin
            d_ff[k]    <= DIFF_W'(pick(corner[k], ax_sel)) - DIFF_W'(level_value);
            side_ff[k] <= (DIFF_W'(pick(corner[k], ax_sel)) - DIFF_W'(level_value)) >= 0;
         end
         c0_center_ff <= ((DIFF_W'(pick(left_ff, ax_sel)) - DIFF_W'(level_value)) >= 0)
                         == ((DIFF_W'(center_ff) - DIFF_W'(level_value)) >= 0);
      end
      if (cmd.lerp) begin
         p_ff[cmd.edge_sel].x <= lerp_f(ea.x, eb.x, tq);
         p_ff[cmd.edge_sel].y <= lerp_f(ea.y, eb.y, tq);
         p_ff[cmd.edge_sel].z <= lerp_f(ea.z, eb.z, tq);
      end
      if (cmd.emit) begin
         if (status.cross_count == 3'd2) begin
            // two crossings: in edge order
            seg_ff.a <= p_ff[status.cross_mask[0] ? 0 : (status.cross_mask[1] ? 1 : 2)];
            seg_ff.b <= p_ff[status.cross_mask[3] ? 3 : (status.cross_mask[2] ? 2 : 1)];
            seg_ff.last <= 1'b1;
         end else if (c0_center_ff) begin
            seg_ff.a    <= cmd.seg_sel ? p_ff[2] : p_ff[0];
            seg_ff.b    <= cmd.seg_sel ? p_ff[3] : p_ff[1];
            seg_ff.last <= cmd.seg_sel;
         end else begin
            seg_ff.a    <= cmd.seg_sel ? p_ff[3] : p_ff[1];
            seg_ff.b    <= cmd.seg_sel ? p_ff[0] : p_ff[2];
            seg_ff.last <= cmd.seg_sel;
         end
      end
   end

   always_comb begin
      status.has_cell = cell_ff;
      for (int k = 0; k < 4; k++) begin
         status.cross_mask[k] = side_ff[k] != side_ff[(k + 1) % 4];
      end
      status.cross_count = 3'(status.cross_mask[0]) + 3'(status.cross_mask[1])
                         + 3'(status.cross_mask[2]) + 3'(status.cross_mask[3]);
      status.div_done = dv_done;
   end

   assign seg_out = seg_ff;
endmodule

/* sv/msq_control.sv */
// ============================================================================
// msq_control
// Sequencer: accept point, classify, divide each crossing, emit segments.
// ============================================================================
module msq_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output msq_pkg::cmd_type    cmd,
   input  msq_pkg::status_type status
);
   import msq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_CLASS, S_CHECK, S_DIV, S_WAIT, S_EMIT, S_OUT, S_COMMIT
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] edge_ff, edge_in;
   logic       seg_ff, seg_in;
   logic       rsp_ff, rsp_in;

   always_comb begin
      state_in = state_ff;
      edge_in  = edge_ff;
      seg_in   = seg_ff;
      rsp_in   = rsp_ff;
      cmd      = '0;
      cmd.edge_sel = edge_ff;
      cmd.seg_sel  = seg_ff;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CLASS;
            end
         end
         S_CLASS: begin
            cmd.classify = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            edge_in = 2'd0;
            seg_in  = 1'b0;
            if (status.has_cell && status.cross_count != 3'd0) state_in = S_DIV;
            else state_in = S_COMMIT;
         end
         S_DIV: begin
            if (status.cross_mask[edge_ff]) begin
               cmd.div_start = 1'b1;
               state_in = S_WAIT;
            end else if (edge_ff == 2'd3) begin
               // last edge has no crossing: all crossings are done
               state_in = S_EMIT;
            end else begin
               edge_in = edge_ff + 2'd1;
            end
         end
         S_WAIT: begin
            if (status.div_done) begin
               cmd.lerp = 1'b1;
               if (edge_ff == 2'd3) begin
                  state_in = S_EMIT;
               end else begin
                  edge_in  = edge_ff + 2'd1;
                  state_in = S_DIV;
               end
            end
         end
         S_EMIT: begin
            cmd.emit = 1'b1;
            rsp_in   = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               rsp_in = 1'b0;
               if (status.cross_count == 3'd4 && !seg_ff) begin
                  seg_in   = 1'b1;
                  state_in = S_EMIT;
               end else begin
                  state_in = S_COMMIT;
               end
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         edge_ff  <= '0;
         seg_ff   <= 1'b0;
         rsp_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         edge_ff  <= edge_in;
         seg_ff   <= seg_in;
         rsp_ff   <= rsp_in;
      end
   end

   assign rsp_valid = rsp_ff;
endmodule

/* sv/marching_squares_contour_cells_core.sv */
// ============================================================================
// marching_squares_contour_cells_core
// Marching-squares contour segments from a raster stream of grid points.
// ============================================================================
// One point is taken at a time. A point that closes no cell, or a cell with
// no crossing, goes straight from classification to commit. Each crossing
// edge is divided in turn in a single shared bit-serial divider that forms
// the Q2.30 interpolation fraction; a saddle cell emits two segments, and
// each segment waits for rsp_ready.
// The previous row lives in a line store of MAX_ROW_POINTS entries.
module marching_squares_contour_cells_core #(
   parameter int MAX_ROW_POINTS = msq_pkg::MAX_ROW_POINTS_DEF
) (
   input  logic clock,
   input  logic reset,
   msq_req_if.sink   req,
   msq_rsp_if.source rsp,
   msq_csr_if.sink   csr
);
   import msq_pkg::*;

   logic [AXIS_W-1:0] axis_ff;
   coord_type         level_ff;
   logic [PPR_W-1:0]  ppr_ff;
   cmd_type           cmd;
   status_type        status;
   segment_type       seg;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff  <= AXIS_W'(2);
         level_ff <= '0;
         ppr_ff   <= PPR_W'(1024);
      end else if (csr.valid) begin
         unique case (csr.index)
            REG_AXIS_SELECT:    axis_ff  <= csr.data[AXIS_W-1:0];
            REG_LEVEL_VALUE:    level_ff <= csr.data;
            REG_POINTS_PER_ROW: ppr_ff   <= csr.data[PPR_W-1:0];
            default: ;
         endcase
      end
   end

   msq_control u_ctrl (
      .clock (clock), .reset (reset),
      .req_valid (req.valid), .req_ready (req.ready),
      .rsp_valid (rsp.valid), .rsp_ready (rsp.ready),
      .cmd (cmd), .status (status)
   );

   msq_datapath #(.MAX_ROW_POINTS (MAX_ROW_POINTS)) u_dp (
      .clock (clock), .reset (reset), .cmd (cmd), .status (status),
      .in_frame_start (req.frame_start),
      .in_point ({req.px, req.py, req.pz}),
      .in_center (req.center_value),
      .axis_select (axis_ff), .level_value (level_ff), .points_per_row (ppr_ff),
      .seg_out (seg)
   );

   assign rsp.ax = seg.a.x;
   assign rsp.ay = seg.a.y;
   assign rsp.az = seg.a.z;
   assign rsp.bx = seg.b.x;
   assign rsp.by_coord = seg.b.y;
   assign rsp.bz = seg.b.z;
   assign rsp.last_segment = seg.last;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("input taken while segment pending");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.classify, cmd.div_start, cmd.lerp, cmd.emit, cmd.commit}))
      else $error("conflicting datapath commands");
   a_even_cross: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (status.cross_count == 3'd2 || status.cross_count == 3'd4))
      else $error("odd crossing count at emit");
endmodule
